[hw/rtl/uv_sphere_mesh_generator_assert.svh]
// Assertion macros for the sphere mesh generator.
// Each macro samples on aclk and is switched off while aresetn is low.
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define USMG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define USMG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define USMG_ASSERT_IMP(lbl, ante, cons, msg)
`define USMG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/usmg_pkg.sv]
`timescale 1ns / 1ps
package usmg_pkg;

    localparam int SEG_W            = 9;
    localparam int MAX_SEGMENTS     = 256;
    localparam int TRIG_TABLE_DEPTH = 1024;
    localparam int SINE_W           = 15;
    localparam int TEX_QW           = 16;
    localparam int TEXN_W           = 26;
    localparam int POS_W            = 24;
    localparam int TEX_W            = 17;
    localparam int IDX_W            = 17;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_LON_SEG    = 3'd0,
        REG_LAT_SEG    = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_TEX_LEFT   = 3'd3,
        REG_TEX_TOP    = 3'd4,
        REG_TEX_WIDTH  = 3'd5,
        REG_TEX_HEIGHT = 3'd6
    } usmg_reg_t;

    typedef struct packed {
        logic             mode;
        logic             oor;
        logic             u_neg;
        logic             v_neg;
        logic [IDX_W-1:0] ring;
    } usmg_side_t;

    typedef struct packed {
        logic             mode;
        logic             oor;
        logic [IDX_W-1:0] ring;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } usmg_post_t;

    function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] v);
        logic [SEG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SEG_W'(1);
        end else if (v > SEG_W'(MAX_SEGMENTS)) begin
            r = SEG_W'(MAX_SEGMENTS);
        end
        return r;
    endfunction

endpackage

[hw/rtl/usmg_div.sv]
`timescale 1ns / 1ps
module usmg_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 9,
    parameter int QUO_W = 16
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [W-1:0]     rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [W-1:0]     rem_in;
        logic [W-1:0]     div_sh;
        logic [W-1:0]     rem_next;
        logic [QUO_W-1:0] quo_in;
        logic [QUO_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in = W'(num);
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign div_sh = W'(den) << (QUO_W - 1 - k);

        always_comb begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= div_sh) begin
                rem_next = rem_in - div_sh;
                quo_next[QUO_W-1-k] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

[hw/rtl/usmg_sine_rom.sv]
`timescale 1ns / 1ps
module usmg_sine_rom #(
    parameter int TableDepth = usmg_pkg::TRIG_TABLE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [$clog2(TableDepth+1)-1:0] addr_a,
    input  logic [$clog2(TableDepth+1)-1:0] addr_b,
    output logic [usmg_pkg::SINE_W-1:0]  data_a,
    output logic [usmg_pkg::SINE_W-1:0]  data_b
);

    typedef logic [usmg_pkg::SINE_W-1:0] sine_arr_t [TableDepth+1];

    localparam logic [63:0] TermDiv [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

    function automatic sine_arr_t build_sine();
        sine_arr_t          t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 k;
        int                 n;
        for (k = 0; k <= TableDepth; k++) begin
            x    = (usmg_pkg::HALF_PI_Q30 * 64'(k) + 64'(TableDepth / 2)) / TableDepth;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / TermDiv[n-1];
                if (n[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            t[k] = usmg_pkg::SINE_W'((sum + 64'sd32768) >>> 16);
        end
        return t;
    endfunction

    localparam sine_arr_t SINE = build_sine();

    logic [usmg_pkg::SINE_W-1:0] data_a_reg;
    logic [usmg_pkg::SINE_W-1:0] data_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_a_reg <= SINE[addr_a];
            data_b_reg <= SINE[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

[hw/rtl/uv_sphere_mesh_generator.sv]
`timescale 1ns / 1ps
// UV sphere mesh generator.
// Input beats (s_valid/s_ready) carry mode, lat_step and lon_step. Mode 0 asks
// for one grid vertex: position (Q9.14) and texture coordinates (Q2.14).
// Mode 1 asks for one grid cell and returns two triangle beats of vertex
// indices, the second one flagged m_last. Indices outside the configured
// grid return a single beat with m_out_of_range and m_last set.
// Segment counts, radius and the texture rectangle sit in APB registers at
// byte offsets 0x00..0x18; write them only while no beat is in flight.
// A beat passes through stage A, the bit-per-stage phase and texture dividers,
// the sine table read, two multiplier stages, the rounding stage and the
// output register. The pipe takes one vertex beat per cycle while it is not
// held by back-pressure; a cell holds the pipe while its first triangle is
// loaded, so that the second one can follow.
// Reset clears the pipeline valid bits and loads the register defaults.
// When a beat waits in the tail stage while the output register is full and
// m_ready is low, the whole pipeline holds in place and s_ready drops; while
// the tail is empty the pipe advances.
`include "uv_sphere_mesh_generator_assert.svh"
module uv_sphere_mesh_generator #(
    parameter int TRIG_TABLE_DEPTH = usmg_pkg::TRIG_TABLE_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [4:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic [usmg_pkg::SEG_W-1:0]            s_lat_step,
    input  logic [usmg_pkg::SEG_W-1:0]            s_lon_step,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [usmg_pkg::POS_W-1:0]     m_pos_x,
    output logic signed [usmg_pkg::POS_W-1:0]     m_pos_y,
    output logic signed [usmg_pkg::POS_W-1:0]     m_pos_z,
    output logic signed [usmg_pkg::TEX_W-1:0]     m_tex_u,
    output logic signed [usmg_pkg::TEX_W-1:0]     m_tex_v,
    output logic [usmg_pkg::IDX_W-1:0]            m_corner_a,
    output logic [usmg_pkg::IDX_W-1:0]            m_corner_b,
    output logic [usmg_pkg::IDX_W-1:0]            m_corner_c,
    output logic                                  m_out_of_range,
    output logic                                  m_last
);

    localparam int D      = TRIG_TABLE_DEPTH;
    localparam int SEG_W  = usmg_pkg::SEG_W;
    localparam int AW     = $clog2(D + 1);
    localparam int PH_W   = $clog2(5 * D + 1);
    localparam int PT_QW  = $clog2(4 * D + 1);
    localparam int DQ     = (PT_QW > usmg_pkg::TEX_QW) ? PT_QW : usmg_pkg::TEX_QW;
    localparam int NT_W   = SEG_W + PT_QW + 1;
    localparam int TEXN_W = usmg_pkg::TEXN_W;
    localparam int POS_W  = usmg_pkg::POS_W;
    localparam int TEX_W  = usmg_pkg::TEX_W;
    localparam int IDX_W  = usmg_pkg::IDX_W;
    localparam int SW     = usmg_pkg::SINE_W;
    localparam int SF     = DQ + 4;
    localparam int NSTG   = DQ + 5;

    localparam logic [PH_W-1:0] P1 = PH_W'(D);
    localparam logic [PH_W-1:0] P2 = PH_W'(2 * D);
    localparam logic [PH_W-1:0] P3 = PH_W'(3 * D);
    localparam logic [PH_W-1:0] P4 = PH_W'(4 * D);

    function automatic logic [AW:0] sin_addr(input logic [PH_W-1:0] p);
        logic [PH_W-1:0] r;
        logic [PH_W-1:0] a;
        logic            neg;
        r = (p >= P4) ? p - P4 : p;
        if (r < P1) begin
            a   = r;
            neg = 1'b0;
        end else if (r < P2) begin
            a   = P2 - r;
            neg = 1'b0;
        end else if (r < P3) begin
            a   = r - P2;
            neg = 1'b1;
        end else begin
            a   = P4 - r;
            neg = 1'b1;
        end
        return {neg, a[AW-1:0]};
    endfunction

    function automatic logic signed [15:0] apply_sign(input logic neg,
                                                      input logic [SW-1:0] mag);
        logic signed [15:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    // configuration registers
    logic [SEG_W-1:0]   lon_seg_reg;
    logic [SEG_W-1:0]   lat_seg_reg;
    logic [15:0]        radius_reg;
    logic signed [15:0] tex_left_reg;
    logic signed [15:0] tex_top_reg;
    logic signed [15:0] tex_width_reg;
    logic signed [15:0] tex_height_reg;
    logic               cfg_wr;
    usmg_pkg::usmg_reg_t cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = usmg_pkg::usmg_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lon_seg_reg    <= SEG_W'(128);
            lat_seg_reg    <= SEG_W'(128);
            radius_reg     <= 16'd256;
            tex_left_reg   <= '0;
            tex_top_reg    <= '0;
            tex_width_reg  <= '0;
            tex_height_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                usmg_pkg::REG_LON_SEG:    lon_seg_reg <= usmg_pkg::clamp_seg(pwdata[SEG_W-1:0]);
                usmg_pkg::REG_LAT_SEG:    lat_seg_reg <= usmg_pkg::clamp_seg(pwdata[SEG_W-1:0]);
                usmg_pkg::REG_RADIUS:     radius_reg     <= pwdata[15:0];
                usmg_pkg::REG_TEX_LEFT:   tex_left_reg   <= pwdata[15:0];
                usmg_pkg::REG_TEX_TOP:    tex_top_reg    <= pwdata[15:0];
                usmg_pkg::REG_TEX_WIDTH:  tex_width_reg  <= pwdata[15:0];
                usmg_pkg::REG_TEX_HEIGHT: tex_height_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            usmg_pkg::REG_LON_SEG:    prdata = 32'(lon_seg_reg);
            usmg_pkg::REG_LAT_SEG:    prdata = 32'(lat_seg_reg);
            usmg_pkg::REG_RADIUS:     prdata = 32'(radius_reg);
            usmg_pkg::REG_TEX_LEFT:   prdata = 32'(tex_left_reg);
            usmg_pkg::REG_TEX_TOP:    prdata = 32'(tex_top_reg);
            usmg_pkg::REG_TEX_WIDTH:  prdata = 32'(tex_width_reg);
            usmg_pkg::REG_TEX_HEIGHT: prdata = 32'(tex_height_reg);
            default:                  prdata = '0;
        endcase
    end

    // pipeline control
    logic [NSTG-1:0] vld_reg;
    logic            adv;
    logic            f_two;
    logic            o_load;
    logic            half_reg;
    logic            o_valid_reg;

    assign o_load  = vld_reg[SF] && (!o_valid_reg || m_ready);
    assign adv     = !vld_reg[SF] || (o_load && (!f_two || half_reg));
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    // stage A: range check, divider numerators, cell base index
    logic                 lat_ok;
    logic                 lon_ok;
    logic [NT_W-1:0]      nt_next;
    logic [NT_W-1:0]      na_next;
    logic signed [25:0]   tu_prod;
    logic signed [25:0]   tv_prod;
    logic [TEXN_W-1:0]    tu_next;
    logic [TEXN_W-1:0]    tv_next;
    logic [18:0]          ring_full;
    usmg_pkg::usmg_side_t side_next;

    logic [NT_W-1:0]      a_nt_reg;
    logic [NT_W-1:0]      a_na_reg;
    logic [TEXN_W-1:0]    a_tu_reg;
    logic [TEXN_W-1:0]    a_tv_reg;
    usmg_pkg::usmg_side_t side_reg [DQ+1];

    always_comb begin
        lat_ok    = s_mode ? (s_lat_step < lat_seg_reg) : (s_lat_step <= lat_seg_reg);
        lon_ok    = s_mode ? (s_lon_step < lon_seg_reg) : (s_lon_step <= lon_seg_reg);
        nt_next   = NT_W'(s_lon_step) * NT_W'(4 * D) + NT_W'(lon_seg_reg >> 1);
        na_next   = NT_W'(s_lat_step) * NT_W'(2 * D) + NT_W'(lat_seg_reg >> 1);
        tu_prod   = tex_width_reg * $signed({1'b0, s_lon_step});
        tv_prod   = tex_height_reg * $signed({1'b0, s_lat_step});
        tu_next   = (tu_prod[25] ? TEXN_W'(-tu_prod) : TEXN_W'(tu_prod))
                    + TEXN_W'(lon_seg_reg >> 1);
        tv_next   = (tv_prod[25] ? TEXN_W'(-tv_prod) : TEXN_W'(tv_prod))
                    + TEXN_W'(lat_seg_reg >> 1);
        ring_full = 19'(s_lat_step) * 19'({1'b0, lon_seg_reg} + 10'd1) + 19'(s_lon_step);
        side_next.mode  = s_mode;
        side_next.oor   = !(lat_ok && lon_ok);
        side_next.u_neg = tu_prod[25];
        side_next.v_neg = tv_prod[25];
        side_next.ring  = ring_full[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_nt_reg    <= nt_next;
            a_na_reg    <= na_next;
            a_tu_reg    <= tu_next;
            a_tv_reg    <= tv_next;
            side_reg[0] <= side_next;
            for (int k = 1; k <= DQ; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // dividers
    logic [DQ-1:0] q_t;
    logic [DQ-1:0] q_a;
    logic [DQ-1:0] q_u;
    logic [DQ-1:0] q_v;

    usmg_div #(.NUM_W(NT_W), .DEN_W(SEG_W), .QUO_W(DQ)) u_div_t (
        .aclk(aclk), .en(adv), .num(a_nt_reg), .den(lon_seg_reg), .quo(q_t)
    );
    usmg_div #(.NUM_W(NT_W), .DEN_W(SEG_W), .QUO_W(DQ)) u_div_a (
        .aclk(aclk), .en(adv), .num(a_na_reg), .den(lat_seg_reg), .quo(q_a)
    );
    usmg_div #(.NUM_W(TEXN_W), .DEN_W(SEG_W), .QUO_W(DQ)) u_div_u (
        .aclk(aclk), .en(adv), .num(a_tu_reg), .den(lon_seg_reg), .quo(q_u)
    );
    usmg_div #(.NUM_W(TEXN_W), .DEN_W(SEG_W), .QUO_W(DQ)) u_div_v (
        .aclk(aclk), .en(adv), .num(a_tv_reg), .den(lat_seg_reg), .quo(q_v)
    );

    // stage B: quadrant fold, table read, texture offset
    logic [PH_W-1:0]      pt;
    logic [PH_W-1:0]      pa;
    logic [AW:0]          ct_sel;
    logic [AW:0]          st_sel;
    logic [AW:0]          cp_sel;
    logic [AW:0]          sp_sel;
    logic [TEX_W-1:0]     qu17;
    logic [TEX_W-1:0]     qv17;
    usmg_pkg::usmg_side_t dside;
    usmg_pkg::usmg_post_t post_next;
    usmg_pkg::usmg_post_t b_post_reg;
    logic [3:0]           b_neg_reg;
    logic [SW-1:0]        ct_mag;
    logic [SW-1:0]        st_mag;
    logic [SW-1:0]        cp_mag;
    logic [SW-1:0]        sp_mag;

    always_comb begin
        dside  = side_reg[DQ];
        pt     = PH_W'(q_t);
        pa     = PH_W'(q_a);
        ct_sel = sin_addr(pt + P1);
        st_sel = sin_addr(pt);
        cp_sel = sin_addr(pa);
        sp_sel = sin_addr(pa + P1);
        qu17   = TEX_W'(q_u[usmg_pkg::TEX_QW-1:0]);
        qv17   = TEX_W'(q_v[usmg_pkg::TEX_QW-1:0]);
        post_next.mode  = dside.mode;
        post_next.oor   = dside.oor;
        post_next.ring  = dside.ring;
        post_next.tex_u = TEX_W'(tex_left_reg) + (dside.u_neg ? -qu17 : qu17);
        post_next.tex_v = TEX_W'(tex_top_reg) + (dside.v_neg ? -qv17 : qv17);
    end

    usmg_sine_rom #(.TableDepth(D)) u_rom_theta (
        .aclk(aclk), .en(adv), .addr_a(ct_sel[AW-1:0]), .addr_b(st_sel[AW-1:0]),
        .data_a(ct_mag), .data_b(st_mag)
    );
    usmg_sine_rom #(.TableDepth(D)) u_rom_phi (
        .aclk(aclk), .en(adv), .addr_a(cp_sel[AW-1:0]), .addr_b(sp_sel[AW-1:0]),
        .data_a(cp_mag), .data_b(sp_mag)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_post_reg <= post_next;
            b_neg_reg  <= {sp_sel[AW], cp_sel[AW], st_sel[AW], ct_sel[AW]};
        end
    end

    // stage C: trig products for x and z, radius scaling for y
    logic signed [16:0]   rad17;
    logic signed [31:0]   c_px_reg;
    logic signed [31:0]   c_pz_reg;
    logic signed [32:0]   c_py_reg;
    usmg_pkg::usmg_post_t c_post_reg;

    assign rad17 = $signed({1'b0, radius_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_px_reg   <= apply_sign(b_neg_reg[2], cp_mag) * apply_sign(b_neg_reg[0], ct_mag);
            c_pz_reg   <= apply_sign(b_neg_reg[2], cp_mag) * apply_sign(b_neg_reg[1], st_mag);
            c_py_reg   <= rad17 * apply_sign(b_neg_reg[3], sp_mag);
            c_post_reg <= b_post_reg;
        end
    end

    // stage D: radius scaling for x and z
    logic signed [48:0]   d_x_reg;
    logic signed [48:0]   d_z_reg;
    logic signed [32:0]   d_y_reg;
    usmg_pkg::usmg_post_t d_post_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_x_reg    <= rad17 * c_px_reg;
            d_z_reg    <= rad17 * c_pz_reg;
            d_y_reg    <= c_py_reg;
            d_post_reg <= c_post_reg;
        end
    end

    // stage F: round half away from zero
    logic [48:0]          x_mag;
    logic [48:0]          z_mag;
    logic [32:0]          y_mag;
    logic [48:0]          x_rnd;
    logic [48:0]          z_rnd;
    logic [32:0]          y_rnd;
    logic [POS_W-1:0]     x_next;
    logic [POS_W-1:0]     y_next;
    logic [POS_W-1:0]     z_next;
    logic [POS_W-1:0]     f_x_reg;
    logic [POS_W-1:0]     f_y_reg;
    logic [POS_W-1:0]     f_z_reg;
    usmg_pkg::usmg_post_t f_post_reg;

    always_comb begin
        x_mag  = d_x_reg[48] ? 49'(-d_x_reg) : 49'(d_x_reg);
        z_mag  = d_z_reg[48] ? 49'(-d_z_reg) : 49'(d_z_reg);
        y_mag  = d_y_reg[32] ? 33'(-d_y_reg) : 33'(d_y_reg);
        x_rnd  = (x_mag + (49'd1 << 21)) >> 22;
        z_rnd  = (z_mag + (49'd1 << 21)) >> 22;
        y_rnd  = (y_mag + 33'd128) >> 8;
        x_next = d_x_reg[48] ? -x_rnd[POS_W-1:0] : x_rnd[POS_W-1:0];
        z_next = d_z_reg[48] ? -z_rnd[POS_W-1:0] : z_rnd[POS_W-1:0];
        y_next = d_y_reg[32] ? -y_rnd[POS_W-1:0] : y_rnd[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_x_reg    <= x_next;
            f_y_reg    <= y_next;
            f_z_reg    <= z_next;
            f_post_reg <= d_post_reg;
        end
    end

    // output register; a cell is split into two beats
    logic [IDX_W-1:0] next_row;
    logic [POS_W-1:0] o_x_reg;
    logic [POS_W-1:0] o_y_reg;
    logic [POS_W-1:0] o_z_reg;
    logic [TEX_W-1:0] o_u_reg;
    logic [TEX_W-1:0] o_v_reg;
    logic [IDX_W-1:0] o_a_reg;
    logic [IDX_W-1:0] o_b_reg;
    logic [IDX_W-1:0] o_c_reg;
    logic             o_oor_reg;
    logic             o_last_reg;

    assign f_two    = f_post_reg.mode && !f_post_reg.oor;
    assign next_row = f_post_reg.ring + IDX_W'(lon_seg_reg) + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            half_reg    <= 1'b0;
        end else begin
            if (o_load) begin
                o_valid_reg <= 1'b1;
            end else if (m_ready) begin
                o_valid_reg <= 1'b0;
            end
            if (o_load && f_two) begin
                half_reg <= !half_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_x_reg    <= '0;
            o_y_reg    <= '0;
            o_z_reg    <= '0;
            o_u_reg    <= '0;
            o_v_reg    <= '0;
            o_a_reg    <= '0;
            o_b_reg    <= '0;
            o_c_reg    <= '0;
            o_oor_reg  <= f_post_reg.oor;
            o_last_reg <= !f_two || half_reg;
            if (!f_post_reg.oor && !f_post_reg.mode) begin
                o_x_reg <= f_x_reg;
                o_y_reg <= f_y_reg;
                o_z_reg <= f_z_reg;
                o_u_reg <= f_post_reg.tex_u;
                o_v_reg <= f_post_reg.tex_v;
            end
            if (f_two) begin
                o_a_reg <= half_reg ? next_row : f_post_reg.ring;
                o_b_reg <= half_reg ? next_row + IDX_W'(1) : next_row;
                o_c_reg <= f_post_reg.ring + IDX_W'(1);
            end
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_pos_x        = o_x_reg;
    assign m_pos_y        = o_y_reg;
    assign m_pos_z        = o_z_reg;
    assign m_tex_u        = o_u_reg;
    assign m_tex_v        = o_v_reg;
    assign m_corner_a     = o_a_reg;
    assign m_corner_b     = o_b_reg;
    assign m_corner_c     = o_c_reg;
    assign m_out_of_range = o_oor_reg;
    assign m_last         = o_last_reg;

    `USMG_ASSERT_IMP(a_half_cell, half_reg, vld_reg[SF] && f_two, "half set without a cell")
    `USMG_ASSERT_IMP(a_first_tri, m_valid && !m_last, half_reg, "first triangle without half")
    `USMG_ASSERT_IMP(a_drain, !vld_reg[SF], s_ready, "empty tail stage must accept")
    `USMG_ASSERT_IMP(a_oor_last, m_valid && m_out_of_range, m_last && m_corner_a == '0,
                     "out of range beat must be single")
    `USMG_ASSERT_NXT(a_tail_hold, vld_reg[SF] && !s_ready, vld_reg[SF], "stalled tail lost")

endmodule

[sim/tb_uv_sphere_mesh_generator.sv]
`timescale 1ns / 1ps
module tb_uv_sphere_mesh_generator;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE = 40;
    localparam int LONG_HOLD = 400;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int POS_W = usmg_pkg::POS_W;
    localparam int TEX_W = usmg_pkg::TEX_W;
    localparam int IDX_W = usmg_pkg::IDX_W;
    localparam int SEG_W = usmg_pkg::SEG_W;
    localparam int MAX_SEGMENTS = usmg_pkg::MAX_SEGMENTS;
    localparam int TRIG_TABLE_DEPTH = usmg_pkg::TRIG_TABLE_DEPTH;
    localparam logic [63:0] HALF_PI_Q30 = usmg_pkg::HALF_PI_Q30;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_c;
        logic oor;
        logic last;
    } mesh_beat_t;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic s_valid, s_ready, s_mode;
    logic [SEG_W-1:0] s_lat_step, s_lon_step;
    logic m_valid, m_ready;
    logic signed [POS_W-1:0] m_pos_x, m_pos_y, m_pos_z;
    logic signed [TEX_W-1:0] m_tex_u, m_tex_v;
    logic [IDX_W-1:0] m_corner_a, m_corner_b, m_corner_c;
    logic m_out_of_range, m_last;

    mesh_beat_t pending_beats[$];
    int sine_lut[TRIG_TABLE_DEPTH+1];
    int lon_seg, lat_seg;
    longint radius_q, left_q, top_q, width_q, height_q;
    int errors;
    int cycles;
    int stall_pct;
    bit hold_req;
    int hold_left;

    uv_sphere_mesh_generator dut (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (stall_pct == 0) begin
            m_ready <= 1'b1;
        end else if (cycles % 23 < 5) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void build_sine();
        longint unsigned x, x2, term;
        longint sum;
        for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
            x = (HALF_PI_Q30 * k + TRIG_TABLE_DEPTH / 2) / TRIG_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            sine_lut[k] = int'((longint'(sum) + (64'sd1 <<< 15)) >>> 16);
        end
    endfunction

    function automatic longint sine_at(longint p);
        longint q, r;
        p = p % (4 * TRIG_TABLE_DEPTH);
        q = p / TRIG_TABLE_DEPTH;
        r = p % TRIG_TABLE_DEPTH;
        case (q)
            0: return sine_lut[r];
            1: return sine_lut[TRIG_TABLE_DEPTH - r];
            2: return -sine_lut[r];
            default: return -sine_lut[TRIG_TABLE_DEPTH - r];
        endcase
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint mag, q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic int saturate_seg(logic [SEG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SEGMENTS) return MAX_SEGMENTS;
        return v;
    endfunction

    function automatic void predict_mesh(bit mode, int lat, int lon);
        mesh_beat_t b;
        longint pt, pa, ct, st, cp, sp, ring, nxt;
        b = '{default: '0};
        b.last = 1'b1;
        if (mode == 1'b0) begin
            if (lat > lat_seg || lon > lon_seg) begin
                b.oor = 1'b1;
            end else begin
                pt = (longint'(lon) * 4 * TRIG_TABLE_DEPTH + lon_seg / 2) / lon_seg;
                pa = (longint'(lat) * 2 * TRIG_TABLE_DEPTH + lat_seg / 2) / lat_seg;
                ct = sine_at(pt + TRIG_TABLE_DEPTH);
                st = sine_at(pt);
                cp = sine_at(pa);
                sp = sine_at(pa + TRIG_TABLE_DEPTH);
                b.pos_x = POS_W'(round_div(radius_q * (cp * ct), 64'sd1 <<< 22));
                b.pos_y = POS_W'(round_div(radius_q * sp, 256));
                b.pos_z = POS_W'(round_div(radius_q * (cp * st), 64'sd1 <<< 22));
                b.tex_u = TEX_W'(left_q + round_div(width_q * lon, lon_seg));
                b.tex_v = TEX_W'(top_q + round_div(height_q * lat, lat_seg));
            end
            pending_beats.push_back(b);
        end else if (lat >= lat_seg || lon >= lon_seg) begin
            b.oor = 1'b1;
            pending_beats.push_back(b);
        end else begin
            ring = longint'(lat) * (lon_seg + 1) + lon;
            nxt = ring + lon_seg + 1;
            b.corner_a = IDX_W'(ring);
            b.corner_b = IDX_W'(nxt);
            b.corner_c = IDX_W'(ring + 1);
            b.last = 1'b0;
            pending_beats.push_back(b);
            b.corner_a = IDX_W'(nxt);
            b.corner_b = IDX_W'(nxt + 1);
            b.last = 1'b1;
            pending_beats.push_back(b);
        end
    endfunction

    task automatic check_field(string name, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected 0x%0h got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        mesh_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
            end else begin
                e = pending_beats.pop_front();
                check_field("pos_x", e.pos_x, m_pos_x);
                check_field("pos_y", e.pos_y, m_pos_y);
                check_field("pos_z", e.pos_z, m_pos_z);
                check_field("tex_u", POS_W'(e.tex_u), POS_W'(m_tex_u));
                check_field("tex_v", POS_W'(e.tex_v), POS_W'(m_tex_v));
                check_field("corner_a", e.corner_a, m_corner_a);
                check_field("corner_b", e.corner_b, m_corner_b);
                check_field("corner_c", e.corner_c, m_corner_c);
                check_field("out_of_range", e.oor, m_out_of_range);
                check_field("last", e.last, m_last);
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            usmg_pkg::REG_LON_SEG: lon_seg = saturate_seg(val[SEG_W-1:0]);
            usmg_pkg::REG_LAT_SEG: lat_seg = saturate_seg(val[SEG_W-1:0]);
            usmg_pkg::REG_RADIUS: radius_q = val[15:0];
            usmg_pkg::REG_TEX_LEFT: left_q = $signed(val[15:0]);
            usmg_pkg::REG_TEX_TOP: top_q = $signed(val[15:0]);
            usmg_pkg::REG_TEX_WIDTH: width_q = $signed(val[15:0]);
            usmg_pkg::REG_TEX_HEIGHT: height_q = $signed(val[15:0]);
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_sphere(int lon_n, int lat_n, int rad, int lft, int top, int wid, int hgt);
        reg_write(usmg_pkg::REG_LON_SEG, lon_n);
        reg_write(usmg_pkg::REG_LAT_SEG, lat_n);
        reg_write(usmg_pkg::REG_RADIUS, rad);
        reg_write(usmg_pkg::REG_TEX_LEFT, lft);
        reg_write(usmg_pkg::REG_TEX_TOP, top);
        reg_write(usmg_pkg::REG_TEX_WIDTH, wid);
        reg_write(usmg_pkg::REG_TEX_HEIGHT, hgt);
    endtask

    task automatic send_beat(bit mode, int lat, int lon);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_lat_step <= SEG_W'(lat);
        s_lon_step <= SEG_W'(lon);
        do @(posedge aclk); while (!s_ready);
        predict_mesh(mode, lat, lon);
    endtask

    task automatic idle_input(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        idle_input(1);
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic int pick_step(bit mode, int seg);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, mode ? seg - 1 : seg);
        if (r < 92) return mode ? seg - 1 + $urandom_range(0, 1) : seg + $urandom_range(0, 1);
        return $urandom_range(0, 511);
    endfunction

    task automatic send_random(int n);
        int burst;
        bit mode;
        burst = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 1);
            send_beat(mode, pick_step(mode, lat_seg), pick_step(mode, lon_seg));
            burst--;
            if (burst == 0) begin
                idle_input($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    task automatic test_defaults();
        stall_pct = 0;
        send_beat(0, 0, 0);
        send_beat(0, 64, 32);
        send_beat(0, 128, 128);
        send_beat(0, 129, 0);
        send_beat(0, 0, 129);
        send_beat(1, 0, 0);
        send_beat(1, 127, 127);
        send_beat(1, 128, 0);
        send_beat(1, 0, 128);
        drain();
    endtask

    task automatic test_extremes();
        set_sphere(256, 256, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_beat(0, 256, 256);
        send_beat(0, 255, 1);
        send_beat(0, 511, 511);
        send_beat(1, 255, 255);
        send_beat(1, 511, 0);
        drain();
        set_sphere(1, 1, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_beat(0, 1, 1);
        send_beat(0, 0, 1);
        send_beat(1, 0, 0);
        send_beat(1, 1, 0);
        send_beat(0, 2, 0);
        drain();
    endtask

    task automatic test_saturation();
        set_sphere(0, 300, 16'h1234, 16'h2000, 16'hE000, 16'h4000, 16'hC000);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_beat(0, 256, 1);
        send_beat(0, 200, 0);
        send_beat(1, 0, 0);
        send_beat(1, 255, 0);
        send_beat(0, 0, 2);
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
            set_sphere($urandom_range(1, ph < 2 ? 16 : 256), $urandom_range(1, ph < 2 ? 16 : 256),
                       $urandom, $urandom, $urandom, $urandom, $urandom);
            send_random(300);
            drain();
        end
    endtask

    task automatic test_backpressure();
        stall_pct = 20;
        hold_req = 1'b1;
        for (int i = 0; i < 150; i++) begin
            send_beat(i % 2, $urandom_range(0, lat_seg), $urandom_range(0, lon_seg));
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_mode = 1'b0;
        s_lat_step = '0;
        s_lon_step = '0;
        m_ready = 1'b0;
        errors = 0;
        cycles = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        lon_seg = 128;
        lat_seg = 128;
        radius_q = 256;
        left_q = 0;
        top_q = 0;
        width_q = 0;
        height_q = 0;
        build_sine();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_extremes();
        test_saturation();
        test_random();
        test_backpressure();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[uv_sphere_mesh_generator.f]
+incdir+hw/rtl
hw/rtl/usmg_pkg.sv
hw/rtl/usmg_div.sv
hw/rtl/usmg_sine_rom.sv
hw/rtl/uv_sphere_mesh_generator.sv
sim/tb_uv_sphere_mesh_generator.sv
